@@ hdl/brrc_pkg.sv @@
`timescale 1ns / 1ps

package brrc_pkg;

	// Field widths.
	localparam int POS_W   = 31;
	localparam int WIDTH_W = 24;
	localparam int CNT_W   = 32;
	localparam int FRAC_W  = 25;
	localparam int LAST_W  = 32;

	// Shared divider geometry. The dividend is left aligned in NUM_W bits.
	localparam int NUM_W  = 56;
	localparam int DEN_W  = 32;
	localparam int STEP_W = 6;

	localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(NUM_W);
	localparam logic [STEP_W-1:0] MOD_STEPS  = STEP_W'(POS_W);

	localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = WIDTH_W'(100);
	localparam logic [CNT_W-1:0]   COUNT_MAX       = '1;

	// Request codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic             opcode;
		logic [POS_W-1:0] read_position;
		logic             is_tumor;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  tumor_in_bin;
		logic [CNT_W-1:0]  total_in_bin;
		logic [FRAC_W-1:0] tumor_fraction;
		logic [POS_W-1:0]  bin_first;
		logic [LAST_W-1:0] bin_last;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [FRAC_W-1:0] quot;
		logic [DEN_W-1:0]  rem;
	} div_rsp_t;

endpackage

@@ hdl/brrc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is taken from
// the top of num, so a short dividend is left aligned and needs fewer steps.
module brrc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  brrc_pkg::div_req_t req,
	output brrc_pkg::div_rsp_t rsp
);
	import brrc_pkg::*;

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [FRAC_W-1:0] quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				num_q  <= req.num;
				den_q  <= req.den;
				cnt_q  <= req.steps;
				rem_q  <= '0;
				quot_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// The remainder stays below the divisor, so it fits in DEN_W bits.
				rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], 1'b0};
				quot_q <= {quot_q[FRAC_W-2:0], ge};
				cnt_q  <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

@@ hdl/binned_read_ratio_counter.sv @@
`timescale 1ns / 1ps

// Counts tumor reads and all reads in fixed-width position bins whose first
// positions are 1 plus a multiple of bin_width (a width of 0 acts as 1).
// Reads must come in nondecreasing position order; a read at position 0 is
// dropped. A read that lands past the open bin, or a flush request, emits the
// open bin with both counts (saturating at 2^32-1), the tumor fraction in
// Q1.24 (truncated), and the bin's first and last positions. A read inside
// the open bin is counted without the divider, and the next request is
// taken in the cycle after. All division work runs through one shared
// bit-serial divider, one bit a cycle: opening a bin runs the bin alignment;
// closing a bin runs the fraction, waits to see the divider finish, loads
// the output register, and then, when a read opens the next bin, runs the
// alignment again. A flush runs the fraction and loads the output register.
// The output register holds a result until it is taken, while requests
// inside the bin keep flowing; a bin change waits at the output register
// only if an earlier result has not yet been taken. bin_width is written
// through cfg_we and cfg_data and must only change while the block is
// idle; it resets to 100.
module binned_read_ratio_counter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [brrc_pkg::WIDTH_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  brrc_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output brrc_pkg::out_item_t             out_data
);
	import brrc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_FRAC, ST_PUT, ST_MOD} state_t;

	state_t             state_q;
	logic [WIDTH_W-1:0] bin_width_q;
	logic [POS_W-1:0]   start_q;
	logic [CNT_W-1:0]   tumor_tally_q;
	logic [CNT_W-1:0]   total_tally_q;
	logic               open_q;
	logic               pend_open_q;
	logic [POS_W-1:0]   pend_pos_q;
	logic               pend_tumor_q;
	logic               out_valid_q;
	out_item_t          out_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic [WIDTH_W-1:0] w_eff;
	logic [LAST_W-1:0]  last_pos;
	logic               accept;
	logic               is_flush;
	logic               pos_zero;
	logic               past_bin;
	logic               out_free;

	brrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// A width of zero behaves as one position per bin.
	assign w_eff    = (bin_width_q == '0) ? WIDTH_W'(1) : bin_width_q;
	assign last_pos = {1'b0, start_q} + LAST_W'(w_eff) - LAST_W'(1);

	assign accept   = in_valid && !in_stall;
	assign is_flush = (in_data.opcode == OP_FLUSH);
	assign pos_zero = (in_data.read_position == '0);
	assign past_bin = ({1'b0, in_data.read_position} > last_pos);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The divider serves two jobs: the fraction of a closing bin and the
	// alignment remainder (position - 1) mod width of an opening bin.
	always_comb begin
		div_req = '0;
		if (state_q == ST_IDLE && accept) begin
			if (is_flush) begin
				if (open_q) begin
					div_req.start = 1'b1;
					div_req.num   = {tumor_tally_q, 24'b0};
					div_req.den   = total_tally_q;
					div_req.steps = FRAC_STEPS;
				end
			end else if (!pos_zero) begin
				if (!open_q) begin
					div_req.start = 1'b1;
					div_req.num   = {in_data.read_position - POS_W'(1),
						(NUM_W-POS_W)'(0)};
					div_req.den   = DEN_W'(w_eff);
					div_req.steps = MOD_STEPS;
				end else if (past_bin) begin
					div_req.start = 1'b1;
					div_req.num   = {tumor_tally_q, 24'b0};
					div_req.den   = total_tally_q;
					div_req.steps = FRAC_STEPS;
				end
			end
		end else if (state_q == ST_PUT && out_free && pend_open_q) begin
			div_req.start = 1'b1;
			div_req.num   = {pend_pos_q - POS_W'(1), (NUM_W-POS_W)'(0)};
			div_req.den   = DEN_W'(w_eff);
			div_req.steps = MOD_STEPS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			bin_width_q   <= BIN_WIDTH_RESET;
			start_q       <= '0;
			tumor_tally_q <= '0;
			total_tally_q <= '0;
			open_q        <= 1'b0;
			pend_open_q   <= 1'b0;
			pend_pos_q    <= '0;
			pend_tumor_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (cfg_we) begin
				bin_width_q <= cfg_data;
			end
			// In ST_PUT a free output register is always reloaded below.
			if (out_valid_q && !out_stall && state_q != ST_PUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_flush) begin
							if (open_q) begin
								pend_open_q <= 1'b0;
								state_q     <= ST_FRAC;
							end
						end else if (!pos_zero) begin
							pend_pos_q   <= in_data.read_position;
							pend_tumor_q <= in_data.is_tumor;
							if (!open_q) begin
								state_q <= ST_MOD;
							end else if (past_bin) begin
								pend_open_q <= 1'b1;
								state_q     <= ST_FRAC;
							end else begin
								// Read inside the open bin: saturating counts.
								if (in_data.is_tumor && tumor_tally_q != COUNT_MAX) begin
									tumor_tally_q <= tumor_tally_q + CNT_W'(1);
								end
								if (total_tally_q != COUNT_MAX) begin
									total_tally_q <= total_tally_q + CNT_W'(1);
								end
							end
						end
					end
				end
				ST_FRAC: begin
					if (div_rsp.done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						out_q.tumor_in_bin   <= tumor_tally_q;
						out_q.total_in_bin   <= total_tally_q;
						out_q.tumor_fraction <= div_rsp.quot;
						out_q.bin_first      <= start_q;
						out_q.bin_last       <= last_pos;
						if (pend_open_q) begin
							state_q <= ST_MOD;
						end else begin
							open_q        <= 1'b0;
							tumor_tally_q <= '0;
							total_tally_q <= '0;
							state_q       <= ST_IDLE;
						end
					end
				end
				ST_MOD: begin
					if (div_rsp.done) begin
						// The remainder is below the width, so it fits a position.
						start_q       <= pend_pos_q - div_rsp.rem[POS_W-1:0];
						tumor_tally_q <= CNT_W'(pend_tumor_q);
						total_tally_q <= CNT_W'(1);
						open_q        <= 1'b1;
						pend_open_q   <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// An open bin always holds at least one read.
	a_open_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> total_tally_q != '0)
		else $error("open bin with zero total");

	// Tumor count never exceeds the total, even under saturation.
	a_tumor_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		tumor_tally_q <= total_tally_q)
		else $error("tumor count above total");

	// The fraction of any emitted bin is at most one, and its total is nonzero.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.tumor_fraction <= 25'h1000000 && out_q.total_in_bin != '0)
		else $error("emitted bin out of range");

	// The divider is never left running while requests are taken.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_rsp.busy)
		else $error("divider busy while idle");

endmodule
